@@ src/pto_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register indexes, reset values and result codes of the pixel to
// occupancy cell block. No dependencies.
package pto_pkg;

   // Payload field types
   typedef logic [7:0]        chan_type;
   typedef logic [11:0]       coord_type;
   typedef logic [23:0]       index_type;
   typedef logic signed [7:0] value_type;

   // CSR port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam csr_index_type CSR_CHANNEL_COUNT      = 3'd0;
   localparam csr_index_type CSR_ALPHA_PRESENT      = 3'd1;
   localparam csr_index_type CSR_MODE               = 3'd2;
   localparam csr_index_type CSR_INVERT             = 3'd3;
   localparam csr_index_type CSR_OCCUPIED_THRESHOLD = 3'd4;
   localparam csr_index_type CSR_FREE_THRESHOLD     = 3'd5;
   localparam csr_index_type CSR_MAP_WIDTH          = 3'd6;
   localparam csr_index_type CSR_MAP_HEIGHT         = 3'd7;

   // Mode codes; code 3 falls through to the scale path
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_TRINARY = 2'd0;
   localparam mode_type MODE_SCALE   = 2'd1;
   localparam mode_type MODE_RAW     = 2'd2;

   // Map size limits
   localparam int MAP_SIZE_WIDTH = 13;
   typedef logic [MAP_SIZE_WIDTH-1:0] map_size_type;
   localparam map_size_type MAX_WIDTH  = 13'd4096;
   localparam map_size_type MAX_HEIGHT = 13'd4096;

   // Reset values
   localparam logic [2:0]   RST_CHANNEL_COUNT      = 3'd1;
   localparam logic         RST_ALPHA_PRESENT      = 1'b0;
   localparam mode_type     RST_MODE               = MODE_TRINARY;
   localparam logic         RST_INVERT             = 1'b0;
   localparam logic [15:0]  RST_OCCUPIED_THRESHOLD = 16'd42598;
   localparam logic [15:0]  RST_FREE_THRESHOLD     = 16'd12845;
   localparam map_size_type RST_MAP_WIDTH          = 13'd4096;
   localparam map_size_type RST_MAP_HEIGHT         = 13'd4096;

   // Cell codes
   localparam logic [7:0] CODE_OCCUPIED = 8'd100;
   localparam logic [7:0] CODE_FREE     = 8'd0;
   localparam logic [7:0] CODE_UNKNOWN  = 8'hFF;
   localparam logic [6:0] SCALE_SPAN    = 7'd99;

   // Pipeline layout: four arithmetic stages, then one stage per quotient bit
   localparam int QUOT_BITS  = 7;
   localparam int ST_FRONT   = 0;
   localparam int ST_MUL     = 1;
   localparam int ST_CMP     = 2;
   localparam int ST_SCALE   = 3;
   localparam int ST_DIV0    = 4;
   localparam int NUM_STAGES = ST_DIV0 + QUOT_BITS;

   // 0 acts as 1, values above the limit saturate
   function automatic map_size_type clamp_size(map_size_type v, map_size_type hi);
      map_size_type r;
      if (v == '0) begin
         r = map_size_type'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ src/pto_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the pixel to occupancy cell block: one pixel per request.
// Depends on pto_pkg.
interface pto_req_if;
   logic                valid;
   logic                ready;
   pto_pkg::chan_type   chan0;
   pto_pkg::chan_type   chan1;
   pto_pkg::chan_type   chan2;
   pto_pkg::chan_type   chan3;
   pto_pkg::coord_type  pixel_column;
   pto_pkg::coord_type  pixel_row;

   modport source (
      output valid, chan0, chan1, chan2, chan3, pixel_column, pixel_row,
      input  ready
   );
   modport sink (
      input  valid, chan0, chan1, chan2, chan3, pixel_column, pixel_row,
      output ready
   );
endinterface

@@ src/pto_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the pixel to occupancy cell block: one grid cell per request.
// Depends on pto_pkg.
interface pto_rsp_if;
   logic                valid;
   logic                ready;
   pto_pkg::index_type  cell_index;
   pto_pkg::value_type  cell_value;

   modport source (
      output valid, cell_index, cell_value,
      input  ready
   );
   modport sink (
      input  valid, cell_index, cell_value,
      output ready
   );
endinterface

@@ src/pixel_to_occupancy_cell.sv @@
`timescale 1ns / 1ps
// Pixel to occupancy cell converter, top level.
// Depends on pto_pkg, pto_req_if and pto_rsp_if.
//
// Usage:
//   req_chan takes one pixel per request (four channel bytes, column, row);
//   rsp_chan returns one grid cell per request (flipped grid index, int8 code),
//   in request order. Both channels use valid/ready; a transfer happens on a
//   rising clock edge with valid and ready high.
//   csr_* is a write-only register port: csr_write_enable with csr_index and
//   csr_write_data writes one register on that edge. Write only while idle.
// Timing:
//   11 register stages: front end (channel sum, ratio terms, flipped row),
//   multipliers, threshold compare, scale by 99, then a 7-stage restoring
//   divider that makes one quotient bit per stage. One request per cycle
//   sustained while rsp_chan.ready stays high.
// Stall:
//   Each stage carries its own valid bit and loads when it is empty or its
//   successor moves, so bubbles are squeezed out; req_chan.ready drops only
//   when all 11 stages hold a request and rsp_chan.ready is low.
// Reset:
//   Synchronous, active high. Empties the pipeline and loads the register
//   reset values; no memory, no clearing pass.
module pixel_to_occupancy_cell (
   input  logic                      clock,
   input  logic                      reset,
   pto_req_if.sink                   req_chan,
   pto_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  pto_pkg::csr_index_type    csr_index,
   input  pto_pkg::csr_data_type     csr_write_data
);

   localparam int LAST     = pto_pkg::NUM_STAGES - 1;
   localparam int QB       = pto_pkg::QUOT_BITS;
   localparam int PROD_W   = 26;   // 16-bit threshold x 10-bit denominator
   localparam int NUMER_W  = 33;   // 99 x PROD_W

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [2:0]            channel_count_ff;
   logic                  alpha_present_ff;
   pto_pkg::mode_type     mode_ff;
   logic                  invert_ff;
   logic [15:0]           occ_thresh_ff;
   logic [15:0]           free_thresh_ff;
   pto_pkg::map_size_type map_width_ff;
   pto_pkg::map_size_type map_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= pto_pkg::RST_CHANNEL_COUNT;
         alpha_present_ff <= pto_pkg::RST_ALPHA_PRESENT;
         mode_ff          <= pto_pkg::RST_MODE;
         invert_ff        <= pto_pkg::RST_INVERT;
         occ_thresh_ff    <= pto_pkg::RST_OCCUPIED_THRESHOLD;
         free_thresh_ff   <= pto_pkg::RST_FREE_THRESHOLD;
         map_width_ff     <= pto_pkg::RST_MAP_WIDTH;
         map_height_ff    <= pto_pkg::RST_MAP_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pto_pkg::CSR_CHANNEL_COUNT:      channel_count_ff <= csr_write_data[2:0];
            pto_pkg::CSR_ALPHA_PRESENT:      alpha_present_ff <= csr_write_data[0];
            pto_pkg::CSR_MODE:               mode_ff          <= csr_write_data[1:0];
            pto_pkg::CSR_INVERT:             invert_ff        <= csr_write_data[0];
            pto_pkg::CSR_OCCUPIED_THRESHOLD: occ_thresh_ff    <= csr_write_data;
            pto_pkg::CSR_FREE_THRESHOLD:     free_thresh_ff   <= csr_write_data;
            pto_pkg::CSR_MAP_WIDTH:
               map_width_ff  <= csr_write_data[pto_pkg::MAP_SIZE_WIDTH-1:0];
            pto_pkg::CSR_MAP_HEIGHT:
               map_height_ff <= csr_write_data[pto_pkg::MAP_SIZE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control: a stage loads when any stage from it to the
   // output is empty, or the output is being taken.
   // ---------------------------------------------------------------
   logic [LAST:0] v_ff;
   logic [LAST:0] v_in;
   logic [LAST:0] stage_en;

   always_comb begin
      for (int k = 0; k <= LAST; k++) begin
         stage_en[k] = rsp_chan.ready;
         for (int j = 0; j <= LAST; j++) begin
            if (j >= k && !v_ff[j]) begin
               stage_en[k] = 1'b1;
            end
         end
      end
      for (int k = 0; k <= LAST; k++) begin
         if (stage_en[k]) begin
            v_in[k] = (k == 0) ? req_chan.valid : v_ff[(k == 0) ? 0 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = stage_en[0];

   // ---------------------------------------------------------------
   // Stage 0: channel count, averaged channels, sum, ratio terms, flipped row
   // ---------------------------------------------------------------
   logic [2:0]            n_eff;
   logic [2:0]            m_in;
   logic [9:0]            sum_in;
   logic                  alpha_nz_in;
   logic [10:0]           den_wide;
   logic [9:0]            den_in;
   logic [9:0]            num_in;
   pto_pkg::map_size_type h_eff;
   pto_pkg::index_type    flip_in;

   always_comb begin
      priority if (channel_count_ff == 3'd0) begin
         n_eff = 3'd1;
      end else if (channel_count_ff > 3'd4) begin
         n_eff = 3'd4;
      end else begin
         n_eff = channel_count_ff;
      end

      // alpha is left out of the average except in trinary mode or on one channel
      if (mode_ff != pto_pkg::MODE_TRINARY && alpha_present_ff && n_eff > 3'd1) begin
         m_in = n_eff - 3'd1;
      end else begin
         m_in = n_eff;
      end

      sum_in = 10'(req_chan.chan0)
             + ((m_in >= 3'd2) ? 10'(req_chan.chan1) : 10'd0)
             + ((m_in >= 3'd3) ? 10'(req_chan.chan2) : 10'd0)
             + ((m_in >= 3'd4) ? 10'(req_chan.chan3) : 10'd0);

      // alpha byte is the last used channel; a single channel counts as opaque
      unique case (n_eff)
         3'd2:    alpha_nz_in = (req_chan.chan1 != 8'd0);
         3'd3:    alpha_nz_in = (req_chan.chan2 != 8'd0);
         3'd4:    alpha_nz_in = (req_chan.chan3 != 8'd0);
         default: alpha_nz_in = 1'b1;
      endcase

      den_wide = {m_in, 8'd0} - 11'(m_in);
      den_in   = den_wide[9:0];
      num_in   = invert_ff ? sum_in : (den_in - sum_in);

      h_eff   = pto_pkg::clamp_size(map_height_ff, pto_pkg::MAX_HEIGHT);
      flip_in = 24'(h_eff) - 24'd1 - 24'(req_chan.pixel_row);
   end

   logic [2:0]          s0_m_ff;
   logic [9:0]          s0_sum_ff;
   logic [9:0]          s0_den_ff;
   logic [9:0]          s0_num_ff;
   logic                s0_alpha_nz_ff;
   pto_pkg::index_type  s0_flip_ff;
   pto_pkg::coord_type  s0_col_ff;

   always_ff @(posedge clock) begin
      if (stage_en[pto_pkg::ST_FRONT]) begin
         s0_m_ff        <= m_in;
         s0_sum_ff      <= sum_in;
         s0_den_ff      <= den_in;
         s0_num_ff      <= num_in;
         s0_alpha_nz_ff <= alpha_nz_in;
         s0_flip_ff     <= flip_in;
         s0_col_ff      <= req_chan.pixel_column;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: threshold products, scale span, index product, raw average
   // ---------------------------------------------------------------
   pto_pkg::map_size_type w_eff;
   logic [PROD_W-1:0]     prod_o_in;
   logic [PROD_W-1:0]     prod_f_in;
   logic [PROD_W-1:0]     bot_in;
   pto_pkg::index_type    idx_mul_in;
   logic [9:0]            ceil_sum;
   logic [19:0]           fl3_prod;
   logic [19:0]           ce3_prod;
   logic [7:0]            raw_fl;
   logic [7:0]            raw_ce;
   logic [7:0]            raw_in;

   always_comb begin
      prod_o_in = PROD_W'(occ_thresh_ff) * PROD_W'(s0_den_ff);
      prod_f_in = PROD_W'(free_thresh_ff) * PROD_W'(s0_den_ff);
      if (occ_thresh_ff > free_thresh_ff) begin
         bot_in = PROD_W'(occ_thresh_ff - free_thresh_ff) * PROD_W'(s0_den_ff);
      end else begin
         bot_in = '0;
      end

      w_eff      = pto_pkg::clamp_size(map_width_ff, pto_pkg::MAX_WIDTH);
      idx_mul_in = s0_flip_ff * 24'(w_eff);

      // floor and ceil of sum/m; divide by 3 via 683/2048, exact below 2048
      ceil_sum = s0_sum_ff + 10'(s0_m_ff) - 10'd1;
      fl3_prod = 20'(s0_sum_ff) * 20'd683;
      ce3_prod = 20'(ceil_sum) * 20'd683;
      unique case (s0_m_ff)
         3'd2: begin
            raw_fl = s0_sum_ff[8:1];
            raw_ce = ceil_sum[8:1];
         end
         3'd3: begin
            raw_fl = fl3_prod[18:11];
            raw_ce = ce3_prod[18:11];
         end
         3'd4: begin
            raw_fl = s0_sum_ff[9:2];
            raw_ce = ceil_sum[9:2];
         end
         default: begin
            raw_fl = s0_sum_ff[7:0];
            raw_ce = s0_sum_ff[7:0];
         end
      endcase
      raw_in = invert_ff ? (8'd255 - raw_ce) : raw_fl;
   end

   logic [PROD_W-1:0]   s1_prod_o_ff;
   logic [PROD_W-1:0]   s1_prod_f_ff;
   logic [PROD_W-1:0]   s1_bot_ff;
   logic [9:0]          s1_num_ff;
   logic                s1_alpha_nz_ff;
   logic [7:0]          s1_raw_ff;
   pto_pkg::index_type  s1_idx_mul_ff;
   pto_pkg::coord_type  s1_col_ff;

   always_ff @(posedge clock) begin
      if (stage_en[pto_pkg::ST_MUL]) begin
         s1_prod_o_ff   <= prod_o_in;
         s1_prod_f_ff   <= prod_f_in;
         s1_bot_ff      <= bot_in;
         s1_num_ff      <= s0_num_ff;
         s1_alpha_nz_ff <= s0_alpha_nz_ff;
         s1_raw_ff      <= raw_in;
         s1_idx_mul_ff  <= idx_mul_in;
         s1_col_ff      <= s0_col_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: compare ratio with thresholds, pick fixed code, raw average or scale path
   // ---------------------------------------------------------------
   logic [PROD_W-1:0]   num_q16;
   logic                is_occ;
   logic                is_free;
   logic [PROD_W-1:0]   top_in;
   logic [7:0]          fix_in;
   logic                use_q_in;
   pto_pkg::index_type  index_in;

   always_comb begin
      num_q16  = {s1_num_ff, 16'd0};
      is_occ   = num_q16 > s1_prod_o_ff;
      is_free  = num_q16 < s1_prod_f_ff;
      top_in   = num_q16 - s1_prod_f_ff;
      index_in = s1_idx_mul_ff + 24'(s1_col_ff);
      use_q_in = 1'b0;
      priority if (mode_ff == pto_pkg::MODE_RAW) begin
         fix_in = s1_raw_ff;
      end else if (is_occ) begin
         fix_in = pto_pkg::CODE_OCCUPIED;
      end else if (is_free) begin
         fix_in = pto_pkg::CODE_FREE;
      end else if (mode_ff == pto_pkg::MODE_TRINARY || !s1_alpha_nz_ff) begin
         fix_in = pto_pkg::CODE_UNKNOWN;
      end else if (s1_bot_ff == '0) begin
         fix_in = pto_pkg::CODE_FREE;   // equal thresholds: 0/0 reads as 0
      end else begin
         fix_in   = pto_pkg::CODE_FREE;
         use_q_in = 1'b1;
      end
   end

   logic [PROD_W-1:0]   s2_top_ff;
   logic [PROD_W-1:0]   s2_bot_ff;
   logic [7:0]          s2_fix_ff;
   logic                s2_use_q_ff;
   pto_pkg::index_type  s2_index_ff;

   always_ff @(posedge clock) begin
      if (stage_en[pto_pkg::ST_CMP]) begin
         s2_top_ff   <= top_in;
         s2_bot_ff   <= s1_bot_ff;
         s2_fix_ff   <= fix_in;
         s2_use_q_ff <= use_q_in;
         s2_index_ff <= index_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: dividend = 99 * top (top <= bot on the scale path)
   // ---------------------------------------------------------------
   logic [NUMER_W-1:0]  s3_numer_ff;
   logic [PROD_W-1:0]   s3_bot_ff;
   logic [7:0]          s3_fix_ff;
   logic                s3_use_q_ff;
   pto_pkg::index_type  s3_index_ff;

   always_ff @(posedge clock) begin
      if (stage_en[pto_pkg::ST_SCALE]) begin
         s3_numer_ff <= NUMER_W'(s2_top_ff) * NUMER_W'(pto_pkg::SCALE_SPAN);
         s3_bot_ff   <= s2_bot_ff;
         s3_fix_ff   <= s2_fix_ff;
         s3_use_q_ff <= s2_use_q_ff;
         s3_index_ff <= s2_index_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stages 4..10: restoring divider, one quotient bit per stage, MSB first
   // ---------------------------------------------------------------
   logic [NUMER_W-1:0]  dv_rem_ff   [QB-1];
   logic [PROD_W-1:0]   dv_bot_ff   [QB-1];
   logic [QB-1:0]       dv_q_ff     [QB];
   logic [7:0]          dv_fix_ff   [QB];
   logic                dv_use_q_ff [QB];
   pto_pkg::index_type  dv_index_ff [QB];

   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int SHIFT = QB - 1 - j;

      logic [NUMER_W-1:0]  rem_prev;
      logic [PROD_W-1:0]   bot_prev;
      logic [QB-1:0]       q_prev;
      logic [7:0]          fix_prev;
      logic                use_q_prev;
      pto_pkg::index_type  index_prev;
      logic [NUMER_W-1:0]  dsh;
      logic                ge;

      if (j == 0) begin : g_first
         assign rem_prev   = s3_numer_ff;
         assign bot_prev   = s3_bot_ff;
         assign q_prev     = '0;
         assign fix_prev   = s3_fix_ff;
         assign use_q_prev = s3_use_q_ff;
         assign index_prev = s3_index_ff;
      end else begin : g_next
         assign rem_prev   = dv_rem_ff[j-1];
         assign bot_prev   = dv_bot_ff[j-1];
         assign q_prev     = dv_q_ff[j-1];
         assign fix_prev   = dv_fix_ff[j-1];
         assign use_q_prev = dv_use_q_ff[j-1];
         assign index_prev = dv_index_ff[j-1];
      end

      assign dsh = NUMER_W'(bot_prev) << SHIFT;
      assign ge  = rem_prev >= dsh;

      always_ff @(posedge clock) begin
         if (stage_en[pto_pkg::ST_DIV0 + j]) begin
            dv_q_ff[j]     <= {q_prev[QB-2:0], ge};
            dv_fix_ff[j]   <= fix_prev;
            dv_use_q_ff[j] <= use_q_prev;
            dv_index_ff[j] <= index_prev;
         end
      end

      if (j < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[pto_pkg::ST_DIV0 + j]) begin
               dv_rem_ff[j] <= ge ? (rem_prev - dsh) : rem_prev;
               dv_bot_ff[j] <= bot_prev;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response
   // ---------------------------------------------------------------
   assign rsp_chan.valid      = v_ff[LAST];
   assign rsp_chan.cell_index = dv_index_ff[QB-1];
   assign rsp_chan.cell_value = dv_use_q_ff[QB-1]
                              ? pto_pkg::value_type'({1'b0, dv_q_ff[QB-1]})
                              : pto_pkg::value_type'(dv_fix_ff[QB-1]);

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // scale quotient never exceeds 99
   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST] && dv_use_q_ff[QB-1]) |-> (dv_q_ff[QB-1] <= 7'(pto_pkg::SCALE_SPAN)))
      else $error("scale quotient above 99");

   // request side stalls only with every stage full
   a_stall_full: assert property (@(posedge clock)
      !req_chan.ready |-> (&v_ff))
      else $error("request stalled with a bubble in the pipeline");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   // a held response stays valid
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST] && !rsp_chan.ready) |=> v_ff[LAST])
      else $error("response dropped while stalled");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pixel_to_occupancy_cell: directed and random pixels
// under many register settings, checked against an in-bench occupancy predictor.
// Depends on pto_pkg, pto_req_if, pto_rsp_if and the block itself.
module tb_top;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 12;    // pipeline is 11 stages deep
   localparam int STALL_LIMIT   = 1000;  // cycles with no transfer on either side
   localparam int RANDOM_PIXELS = 1550;
   localparam int STEADY_PIXELS = 200;

   // Mode code 3 has no name in the package; the block treats it as scale
   localparam pto_pkg::mode_type MODE_SPARE = 2'd3;

   typedef struct packed {
      pto_pkg::chan_type  chan0;
      pto_pkg::chan_type  chan1;
      pto_pkg::chan_type  chan2;
      pto_pkg::chan_type  chan3;
      pto_pkg::coord_type pixel_column;
      pto_pkg::coord_type pixel_row;
   } pixel_type;

   typedef struct packed {
      pto_pkg::index_type cell_index;
      pto_pkg::value_type cell_value;
   } cell_type;

   // One full register image, in register index order
   typedef struct packed {
      logic [2:0]            channel_count;
      logic                  alpha_present;
      pto_pkg::mode_type     mode;
      logic                  invert;
      logic [15:0]           occupied_threshold;
      logic [15:0]           free_threshold;
      pto_pkg::map_size_type map_width;
      pto_pkg::map_size_type map_height;
   } reg_set_type;

   // Mirrors the registers, predicts one cell per accepted pixel and checks
   // responses in order against the predictions.
   class occupancy_scoreboard;
      reg_set_type regs;
      cell_type    cells_due[$];
      int          errors, checked;
      int          n_occupied, n_free, n_unknown, n_other;

      function new();
         regs = '{pto_pkg::RST_CHANNEL_COUNT, pto_pkg::RST_ALPHA_PRESENT,
                  pto_pkg::RST_MODE, pto_pkg::RST_INVERT,
                  pto_pkg::RST_OCCUPIED_THRESHOLD, pto_pkg::RST_FREE_THRESHOLD,
                  pto_pkg::RST_MAP_WIDTH, pto_pkg::RST_MAP_HEIGHT};
         errors = 0;
         checked = 0;
         n_occupied = 0;
         n_free = 0;
         n_unknown = 0;
         n_other = 0;
      endfunction

      function void write_reg(pto_pkg::csr_index_type idx, pto_pkg::csr_data_type d);
         case (idx)
            pto_pkg::CSR_CHANNEL_COUNT:      regs.channel_count      = d[2:0];
            pto_pkg::CSR_ALPHA_PRESENT:      regs.alpha_present      = d[0];
            pto_pkg::CSR_MODE:               regs.mode = pto_pkg::mode_type'(d[1:0]);
            pto_pkg::CSR_INVERT:             regs.invert             = d[0];
            pto_pkg::CSR_OCCUPIED_THRESHOLD: regs.occupied_threshold = d;
            pto_pkg::CSR_FREE_THRESHOLD:     regs.free_threshold     = d;
            pto_pkg::CSR_MAP_WIDTH:
               regs.map_width  = d[pto_pkg::MAP_SIZE_WIDTH-1:0];
            pto_pkg::CSR_MAP_HEIGHT:
               regs.map_height = d[pto_pkg::MAP_SIZE_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function cell_type expected_cell(pixel_type p);
         pto_pkg::chan_type     ch [4];
         logic [2:0]            n, m;
         logic [9:0]            s, den, num, avg_floor, avg_ceil;
         logic                  alpha_nz;
         logic [39:0]           num_q, occ_q, free_q, bot, grade;
         pto_pkg::map_size_type w, h;
         pto_pkg::index_type    flipped;
         cell_type              c;
         ch[0] = p.chan0;
         ch[1] = p.chan1;
         ch[2] = p.chan2;
         ch[3] = p.chan3;
         // channel count 0 acts as 1, 5..7 act as 4
         n = (regs.channel_count == 3'd0) ? 3'd1 :
             (regs.channel_count > 3'd4) ? 3'd4 : regs.channel_count;
         // alpha drops out of the average except in trinary mode or on one channel
         m = (regs.mode != pto_pkg::MODE_TRINARY && regs.alpha_present && n > 3'd1)
           ? n - 3'd1 : n;
         s = '0;
         for (int k = 0; k < 4; k++)
            if (k < m) s = s + 10'(ch[k]);
         // alpha byte is the last used channel even without alpha_present
         alpha_nz = (n == 3'd1) || (ch[n - 1] != 8'h00);

         if (regs.mode == pto_pkg::MODE_RAW) begin
            avg_floor = s / 10'(m);
            avg_ceil  = (s + 10'(m) - 10'd1) / 10'(m);
            c.cell_value = pto_pkg::value_type'(regs.invert ? 8'(10'd255 - avg_ceil)
                                                            : avg_floor[7:0]);
         end else begin
            den    = 10'(255 * m);
            num    = regs.invert ? s : den - s;
            num_q  = 40'(num) << 16;
            occ_q  = 40'(regs.occupied_threshold) * 40'(den);
            free_q = 40'(regs.free_threshold) * 40'(den);
            if (num_q > occ_q) begin
               c.cell_value = pto_pkg::value_type'(pto_pkg::CODE_OCCUPIED);
            end else if (num_q < free_q) begin
               c.cell_value = pto_pkg::value_type'(pto_pkg::CODE_FREE);
            end else if (regs.mode == pto_pkg::MODE_TRINARY || !alpha_nz) begin
               c.cell_value = pto_pkg::value_type'(pto_pkg::CODE_UNKNOWN);
            end else begin
               // exact floor(99 * (ratio - F) / (O - F)); equal thresholds give 0
               bot = (regs.occupied_threshold > regs.free_threshold) ?
                     40'(den) * 40'(regs.occupied_threshold - regs.free_threshold) : '0;
               grade = (bot == '0) ? '0
                     : (40'(pto_pkg::SCALE_SPAN) * (num_q - free_q)) / bot;
               c.cell_value = pto_pkg::value_type'(grade[7:0]);
            end
         end

         // map size 0 acts as 1, above the limit saturates; index wraps at 24 bits
         w = (regs.map_width == '0) ? pto_pkg::map_size_type'(1) :
             (regs.map_width > pto_pkg::MAX_WIDTH) ? pto_pkg::MAX_WIDTH : regs.map_width;
         h = (regs.map_height == '0) ? pto_pkg::map_size_type'(1) :
             (regs.map_height > pto_pkg::MAX_HEIGHT) ? pto_pkg::MAX_HEIGHT
                                                     : regs.map_height;
         flipped = pto_pkg::index_type'(h) - pto_pkg::index_type'(1)
                 - pto_pkg::index_type'(p.pixel_row);
         c.cell_index = flipped * pto_pkg::index_type'(w)
                      + pto_pkg::index_type'(p.pixel_column);
         return c;
      endfunction

      function void note_pixel(pixel_type p);
         cell_type c;
         c = expected_cell(p);
         cells_due = {cells_due, c};
         if (c.cell_value == pto_pkg::value_type'(pto_pkg::CODE_OCCUPIED)) n_occupied++;
         else if (c.cell_value == pto_pkg::value_type'(pto_pkg::CODE_FREE)) n_free++;
         else if (c.cell_value == pto_pkg::value_type'(pto_pkg::CODE_UNKNOWN)) n_unknown++;
         else n_other++;
      endfunction

      function void check_cell(cell_type got);
         cell_type want;
         if (cells_due.size() == 0) begin
            $error("unexpected cell: index %0d value %0d with no pixel pending",
                   got.cell_index, got.cell_value);
            errors++;
            return;
         end
         want = cells_due.pop_front();
         checked++;
         if (got.cell_index !== want.cell_index) begin
            $error("cell_index mismatch: expected %0d, actual %0d",
                   want.cell_index, got.cell_index);
            errors++;
         end
         if (got.cell_value !== want.cell_value) begin
            $error("cell_value mismatch: expected %0d, actual %0d",
                   want.cell_value, got.cell_value);
            errors++;
         end
      endfunction

      function int pending();
         return cells_due.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   pto_pkg::csr_index_type csr_index;
   pto_pkg::csr_data_type  csr_write_data;

   bit steady = 1'b0;   // set for the tail of the run: no gaps, no stalls
   int sent = 0;
   int setups = 0;
   int idle_cycles = 0;

   occupancy_scoreboard grid_sb;

   pto_req_if req_chan ();
   pto_rsp_if rsp_chan ();

   pixel_to_occupancy_cell i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Predict on every accepted request, check every accepted response.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         grid_sb.note_pixel(pixel_type'{req_chan.chan0, req_chan.chan1, req_chan.chan2,
                                        req_chan.chan3, req_chan.pixel_column,
                                        req_chan.pixel_row});
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         grid_sb.check_cell(cell_type'{rsp_chan.cell_index, rsp_chan.cell_value});
   end

   // Watchdog: a hung handshake on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d cells outstanding",
                  STALL_LIMIT, grid_sb.pending());
         $display("status: fail");
         $finish;
      end
   end

   // Response side: ready drops in random bursts of random length.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic pixel_type pixel_at(pto_pkg::chan_type c0, pto_pkg::chan_type c1,
                                          pto_pkg::chan_type c2, pto_pkg::chan_type c3,
                                          pto_pkg::coord_type col,
                                          pto_pkg::coord_type row);
      return pixel_type'{c0, c1, c2, c3, col, row};
   endfunction

   // Bytes lean toward black and white so the threshold ends get hit often
   function automatic pto_pkg::chan_type random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly pixels inside the current map, some anywhere in the 12-bit range
   function automatic pixel_type random_pixel();
      pixel_type p;
      int        w, h;
      w = (grid_sb.regs.map_width == '0) ? 1 : int'(grid_sb.regs.map_width);
      h = (grid_sb.regs.map_height == '0) ? 1 : int'(grid_sb.regs.map_height);
      p.chan0 = random_byte();
      p.chan1 = random_byte();
      p.chan2 = random_byte();
      p.chan3 = random_byte();
      p.pixel_column = ($urandom_range(0, 4) == 0) ? 12'($urandom)
                                                   : 12'($urandom_range(0, w - 1));
      p.pixel_row    = ($urandom_range(0, 4) == 0) ? 12'($urandom)
                                                   : 12'($urandom_range(0, h - 1));
      return p;
   endfunction

   function automatic reg_set_type random_setup();
      reg_set_type s;
      logic [15:0] a, b;
      s.channel_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4));
      s.alpha_present = 1'($urandom_range(0, 1));
      s.mode          = pto_pkg::mode_type'($urandom_range(0, 3));
      s.invert        = 1'($urandom_range(0, 1));
      a = 16'($urandom_range(0, 65535));
      b = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0: begin       // equal thresholds
            s.occupied_threshold = a;
            s.free_threshold     = a;
         end
         1, 2: begin    // unordered, free may sit above occupied
            s.occupied_threshold = a;
            s.free_threshold     = b;
         end
         default: begin
            s.occupied_threshold = (a > b) ? a : b;
            s.free_threshold     = (a > b) ? b : a;
         end
      endcase
      s.map_width  = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(1, 4096));
      s.map_height = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(1, 4096));
      return s;
   endfunction

   // One request; optional gap first, then hold valid until the block takes it.
   task automatic send_pixel(input pixel_type p);
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.chan0        <= p.chan0;
      req_chan.chan1        <= p.chan1;
      req_chan.chan2        <= p.chan2;
      req_chan.chan3        <= p.chan3;
      req_chan.pixel_column <= p.pixel_column;
      req_chan.pixel_row    <= p.pixel_row;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // Stop sending and wait for every predicted cell to come back.
   task automatic drain_cells();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (grid_sb.pending() != 0) @(negedge clock);
   endtask

   task automatic put_reg(input pto_pkg::csr_index_type idx,
                          input pto_pkg::csr_data_type d);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= d;
      @(posedge clock);
      grid_sb.write_reg(idx, d);
      @(negedge clock);
   endtask

   // Registers change only with the pipeline empty; all eight are rewritten.
   task automatic apply_setup(input reg_set_type s);
      drain_cells();
      repeat (SETTLE_CYCLES) @(negedge clock);
      put_reg(pto_pkg::CSR_CHANNEL_COUNT, pto_pkg::csr_data_type'(s.channel_count));
      put_reg(pto_pkg::CSR_ALPHA_PRESENT, pto_pkg::csr_data_type'(s.alpha_present));
      put_reg(pto_pkg::CSR_MODE,          pto_pkg::csr_data_type'(s.mode));
      put_reg(pto_pkg::CSR_INVERT,        pto_pkg::csr_data_type'(s.invert));
      put_reg(pto_pkg::CSR_OCCUPIED_THRESHOLD, s.occupied_threshold);
      put_reg(pto_pkg::CSR_FREE_THRESHOLD,     s.free_threshold);
      put_reg(pto_pkg::CSR_MAP_WIDTH,     pto_pkg::csr_data_type'(s.map_width));
      put_reg(pto_pkg::CSR_MAP_HEIGHT,    pto_pkg::csr_data_type'(s.map_height));
      csr_write_enable <= 1'b0;
      setups++;
   endtask

   initial begin
      int first_random;
      int burst;
      grid_sb = new();
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = pto_pkg::CSR_CHANNEL_COUNT;
      csr_write_data        = '0;
      req_chan.valid        = 1'b0;
      req_chan.chan0        = '0;
      req_chan.chan1        = '0;
      req_chan.chan2        = '0;
      req_chan.chan3        = '0;
      req_chan.pixel_column = '0;
      req_chan.pixel_row    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- Directed part ---
      // Reset settings: one channel, trinary, 4096 x 4096 map.
      // Black is occupied, white free, mid gray unknown; index corners.
      send_pixel(pixel_at(8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0));
      send_pixel(pixel_at(8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF));
      send_pixel(pixel_at(8'd128, 8'h00, 8'h00, 8'h00, 12'd100, 12'd7));

      // RGBA in scale mode: zero alpha turns an in-between cell unknown.
      apply_setup('{3'd4, 1'b1, pto_pkg::MODE_SCALE, 1'b0, 16'd50000, 16'd10000,
                    13'd4096, 13'd4096});
      send_pixel(pixel_at(8'd128, 8'd128, 8'd128, 8'h00, 12'd5, 12'd9));
      send_pixel(pixel_at(8'd128, 8'd128, 8'd128, 8'hFF, 12'd6, 12'd9));
      send_pixel(pixel_at(8'h00, 8'h00, 8'h00, 8'hFF, 12'd7, 12'd9));
      send_pixel(pixel_at(8'hFF, 8'hFF, 8'hFF, 8'h00, 12'd8, 12'd9));

      // Spare mode code with equal thresholds: ratio exactly on them grades to 0.
      apply_setup('{3'd3, 1'b1, MODE_SPARE, 1'b0, 16'd32768, 16'd32768,
                    13'd640, 13'd480});
      send_pixel(pixel_at(8'd100, 8'd155, 8'd9, 8'h00, 12'd639, 12'd479));
      send_pixel(pixel_at(8'd100, 8'd155, 8'h00, 8'h00, 12'd0, 12'd0));

      // Raw inverted, channel count 0, map size 0 in both directions.
      apply_setup('{3'd0, 1'b1, pto_pkg::MODE_RAW, 1'b1, 16'd0, 16'hFFFF, 13'd0, 13'd0});
      send_pixel(pixel_at(8'h00, 8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0));
      send_pixel(pixel_at(8'hFF, 8'h00, 8'h00, 8'h00, 12'd1, 12'd1));
      send_pixel(pixel_at(8'd77, 8'h00, 8'h00, 8'h00, 12'hFFF, 12'hFFF));

      // Raw, channel count 7, oversize map: truncated averages above 127.
      apply_setup('{3'd7, 1'b0, pto_pkg::MODE_RAW, 1'b0, 16'hFFFF, 16'd0,
                    13'd8191, 13'd5000});
      send_pixel(pixel_at(8'hFF, 8'hFF, 8'hFF, 8'hFE, 12'd0, 12'd0));
      send_pixel(pixel_at(8'h01, 8'h00, 8'h00, 8'h00, 12'd4095, 12'd4095));
      send_pixel(pixel_at(8'd200, 8'd200, 8'd200, 8'd200, 12'd2048, 12'd1));

      // Raw inverted on two channels: the average rounds up before inverting.
      apply_setup('{3'd2, 1'b0, pto_pkg::MODE_RAW, 1'b1, 16'd42598, 16'd12845,
                    13'd1, 13'd4096});
      send_pixel(pixel_at(8'h01, 8'h00, 8'hFF, 8'hFF, 12'd0, 12'd4095));
      send_pixel(pixel_at(8'hFF, 8'hFF, 8'h00, 8'h00, 12'd1, 12'd0));

      // Trinary ignores alpha; widest thresholds leave only full white occupied.
      apply_setup('{3'd4, 1'b1, pto_pkg::MODE_TRINARY, 1'b1, 16'hFFFF, 16'd0,
                    13'd4096, 13'd1});
      send_pixel(pixel_at(8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'd3, 12'd0));
      send_pixel(pixel_at(8'h00, 8'h00, 8'h00, 8'h00, 12'd4, 12'd0));
      send_pixel(pixel_at(8'd10, 8'd20, 8'd30, 8'h00, 12'd5, 12'd0));

      // Single channel with alpha_present: alpha is ignored and counts as nonzero.
      apply_setup('{3'd1, 1'b1, pto_pkg::MODE_SCALE, 1'b0, 16'd60000, 16'd5000,
                    13'd4096, 13'd4096});
      send_pixel(pixel_at(8'd128, 8'h00, 8'h00, 8'h00, 12'd10, 12'd20));
      send_pixel(pixel_at(8'd3, 8'h00, 8'h00, 8'h00, 12'd11, 12'd20));

      // --- Random part ---
      // New register image per burst; the first burst pauses midway until
      // every outstanding cell is back, later ones only now and then.
      first_random = sent;
      while (sent < first_random + RANDOM_PIXELS) begin
         apply_setup(random_setup());
         burst = $urandom_range(30, 120);
         for (int k = 0; k < burst; k++) begin
            if (k == burst / 2 && (sent < first_random + burst || $urandom_range(0, 3) == 0))
               drain_cells();
            send_pixel(random_pixel());
         end
      end

      // Tail at full rate: no gaps on the request side, no stalls on responses.
      apply_setup(random_setup());
      steady = 1'b1;
      repeat (STEADY_PIXELS) send_pixel(random_pixel());

      drain_cells();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d pixels under %0d register images, %0d cells checked",
               sent, setups, grid_sb.checked);
      $display("predicted codes: %0d occupied, %0d free, %0d unknown, %0d graded or raw",
               grid_sb.n_occupied, grid_sb.n_free, grid_sb.n_unknown, grid_sb.n_other);
      if (grid_sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
